@@ rtl/core/line_raster_to_display_writes_macros.svh @@
// assertion macros for the line rasterizer
`ifndef LINE_RASTER_TO_DISPLAY_WRITES_MACROS_SVH
`define LINE_RASTER_TO_DISPLAY_WRITES_MACROS_SVH

`ifndef ASSERT_OFF
// property that must hold at every edge outside reset
`define LRD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("lrd assertion failed");
// antecedent implies consequent on the next edge
`define LRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lrd assertion failed");
`else
`define LRD_ASSERT(label, clk, rst, prop)
`define LRD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ rtl/core/lrd_pkg.sv @@
`timescale 1ns / 1ps
package lrd_pkg;

  // field and port widths
  localparam int FIELD_W   = 16;
  localparam int IN_DATA_W = 80;
  localparam int IN_USER_W = 1;
  localparam int OUT_DATA_W = 8;
  localparam int OUT_USER_W = 3;
  localparam int CFG_IDX_W = 1;

  // input field offsets inside tdata
  localparam int X_START_LSB = 0;
  localparam int Y_START_LSB = 16;
  localparam int X_END_LSB   = 32;
  localparam int Y_END_LSB   = 48;
  localparam int COLOR_LSB   = 64;

  // output tuser bits
  localparam int USER_CMD_BIT   = 0;
  localparam int USER_VALID_BIT = 1;
  localparam int USER_DONE_BIT  = 2;

  // defaults for top-level parameters
  localparam int COORD_BITS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  // register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT = 1'b1;
  localparam logic [FIELD_W-1:0] PANEL_WIDTH_RST  = 16'd240;
  localparam logic [FIELD_W-1:0] PANEL_HEIGHT_RST = 16'd320;

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // display controller commands
  localparam logic [7:0] CMD_COLUMN = 8'h2A;
  localparam logic [7:0] CMD_ROW    = 8'h2B;
  localparam logic [7:0] CMD_WRITE  = 8'h2C;

  // byte slots of one address-window write
  localparam int SLOT_W = 4;
  localparam logic [SLOT_W-1:0] SLOT_COL_CMD = 4'd0;
  localparam logic [SLOT_W-1:0] SLOT_COL_HI0 = 4'd1;
  localparam logic [SLOT_W-1:0] SLOT_COL_LO0 = 4'd2;
  localparam logic [SLOT_W-1:0] SLOT_COL_HI1 = 4'd3;
  localparam logic [SLOT_W-1:0] SLOT_COL_LO1 = 4'd4;
  localparam logic [SLOT_W-1:0] SLOT_ROW_CMD = 4'd5;
  localparam logic [SLOT_W-1:0] SLOT_ROW_HI0 = 4'd6;
  localparam logic [SLOT_W-1:0] SLOT_ROW_LO0 = 4'd7;
  localparam logic [SLOT_W-1:0] SLOT_ROW_HI1 = 4'd8;
  localparam logic [SLOT_W-1:0] SLOT_ROW_LO1 = 4'd9;
  localparam logic [SLOT_W-1:0] SLOT_WR_CMD  = 4'd10;
  localparam logic [SLOT_W-1:0] SLOT_CLR_HI  = 4'd11;
  localparam logic [SLOT_W-1:0] SLOT_CLR_LO  = 4'd12;

  // one classified point handed from front to back
  typedef struct packed {
    logic               clip;
    logic               done;
    logic [FIELD_W-1:0] col;
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] color;
  } point_t;

endpackage

@@ rtl/core/lrd_front.sv @@
`timescale 1ns / 1ps
module lrd_front #(
  parameter int COORD_BITS = lrd_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // x_start, y_start, x_end, y_end, pixel_color
  input  logic [lrd_pkg::IN_DATA_W-1:0]  s_tdata,
  // kind
  input  logic [lrd_pkg::IN_USER_W-1:0]  s_tuser,
  input  logic [lrd_pkg::FIELD_W-1:0]    panel_width,
  input  logic [lrd_pkg::FIELD_W-1:0]    panel_height,
  input  logic                           q_full,
  output logic                           q_push,
  output lrd_pkg::point_t                q_data
);
  import lrd_pkg::*;

  localparam int ERR_W = COORD_BITS + 2;
  localparam int E2_W  = COORD_BITS + 3;

  logic signed [COORD_BITS-1:0] cur_x, cur_y, stop_x, stop_y;
  logic signed [ERR_W-1:0]      span_x, neg_span_y, error_acc;
  logic                         dir_x_neg, dir_y_neg;
  logic [FIELD_W-1:0]           line_color;
  logic                         line_active;

  logic                         accept;
  logic signed [COORD_BITS-1:0] x0, y0, x1, y1;
  logic signed [ERR_W-1:0]      dx, dy;
  logic [FIELD_W-1:0]           col, row;
  logic                         done;
  logic signed [E2_W-1:0]       e2;
  logic                         move_x, move_y;
  logic signed [ERR_W-1:0]      error_acc_next;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // load endpoints at the configured coordinate width
  assign x0 = s_tdata[X_START_LSB +: COORD_BITS];
  assign y0 = s_tdata[Y_START_LSB +: COORD_BITS];
  assign x1 = s_tdata[X_END_LSB +: COORD_BITS];
  assign y1 = s_tdata[Y_END_LSB +: COORD_BITS];
  assign dx = ERR_W'(x1) - ERR_W'(x0);
  assign dy = ERR_W'(y1) - ERR_W'(y0);

  // rotate current point to panel coordinates and classify
  assign row  = FIELD_W'(cur_x);
  assign col  = panel_width - FIELD_W'(cur_y);
  assign done = (cur_x == stop_x) && (cur_y == stop_y);

  assign q_push       = accept && (s_tuser[0] == KIND_STEP) && line_active;
  assign q_data.clip  = (col >= panel_width) || (row >= panel_height);
  assign q_data.done  = done;
  assign q_data.col   = col;
  assign q_data.row   = row;
  assign q_data.color = line_color;

  // error stepping for all octants
  assign e2     = {error_acc, 1'b0};
  assign move_x = e2 >= E2_W'(neg_span_y);
  assign move_y = e2 <= E2_W'(span_x);
  assign error_acc_next = error_acc + (move_x ? neg_span_y : ERR_W'(0))
                                    + (move_y ? span_x : ERR_W'(0));

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (accept && (s_tuser[0] == KIND_LOAD)) begin
      line_active <= 1'b1;
    end else if (q_push && done) begin
      line_active <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (s_tuser[0] == KIND_LOAD)) begin
      cur_x      <= x0;
      cur_y      <= y0;
      stop_x     <= x1;
      stop_y     <= y1;
      span_x     <= dx[ERR_W-1] ? -dx : dx;
      neg_span_y <= dy[ERR_W-1] ? dy : -dy;
      dir_x_neg  <= !(x0 < x1);
      dir_y_neg  <= !(y0 < y1);
      error_acc  <= (dx[ERR_W-1] ? -dx : dx) + (dy[ERR_W-1] ? dy : -dy);
      line_color <= s_tdata[COLOR_LSB +: FIELD_W];
    end else if (q_push && !done) begin
      error_acc <= error_acc_next;
      if (move_x) begin
        cur_x <= dir_x_neg ? cur_x - COORD_BITS'(1) : cur_x + COORD_BITS'(1);
      end
      if (move_y) begin
        cur_y <= dir_y_neg ? cur_y - COORD_BITS'(1) : cur_y + COORD_BITS'(1);
      end
    end
  end

endmodule

@@ rtl/core/lrd_queue.sv @@
`timescale 1ns / 1ps
`include "line_raster_to_display_writes_macros.svh"
module lrd_queue #(
  parameter int DEPTH = lrd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lrd_pkg::point_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output lrd_pkg::point_t head
);
  import lrd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  point_t             entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full      = count == CNT_W'(DEPTH);
  assign not_empty = count != CNT_W'(0);
  assign head      = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `LRD_ASSERT(a_count_bound, clk, rst, count <= CNT_W'(DEPTH))
  `LRD_ASSERT(a_no_push_full, clk, rst, !(push && full))
  `LRD_ASSERT(a_no_pop_empty, clk, rst, !(pop && !not_empty))

endmodule

@@ rtl/core/lrd_back.sv @@
`timescale 1ns / 1ps
`include "line_raster_to_display_writes_macros.svh"
module lrd_back (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           q_valid,
  input  lrd_pkg::point_t                q_head,
  output logic                           q_pop,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // out_byte
  output logic [lrd_pkg::OUT_DATA_W-1:0] m_tdata,
  // is_command, byte_valid, line_done
  output logic [lrd_pkg::OUT_USER_W-1:0] m_tuser,
  // last_of_point
  output logic                           m_tlast
);
  import lrd_pkg::*;

  logic [SLOT_W-1:0]     slot;
  logic                  load_out;
  logic [OUT_DATA_W-1:0] byte_sel;
  logic                  cmd_sel, last_sel, done_sel;

  assign load_out = !m_tvalid || m_tready;
  assign q_pop    = load_out && q_valid && (q_head.clip || (slot == SLOT_CLR_LO));

  // byte of the address-window write for the current slot
  always_comb begin
    byte_sel = '0;
    cmd_sel  = 1'b0;
    last_sel = 1'b0;
    done_sel = 1'b0;
    unique case (slot) inside
      SLOT_COL_CMD: begin
        byte_sel = CMD_COLUMN;
        cmd_sel  = 1'b1;
      end
      SLOT_COL_HI0, SLOT_COL_HI1: byte_sel = q_head.col[15:8];
      SLOT_COL_LO0, SLOT_COL_LO1: byte_sel = q_head.col[7:0];
      SLOT_ROW_CMD: begin
        byte_sel = CMD_ROW;
        cmd_sel  = 1'b1;
      end
      SLOT_ROW_HI0, SLOT_ROW_HI1: byte_sel = q_head.row[15:8];
      SLOT_ROW_LO0, SLOT_ROW_LO1: byte_sel = q_head.row[7:0];
      SLOT_WR_CMD: begin
        byte_sel = CMD_WRITE;
        cmd_sel  = 1'b1;
      end
      SLOT_CLR_HI: byte_sel = q_head.color[15:8];
      SLOT_CLR_LO: begin
        byte_sel = q_head.color[7:0];
        last_sel = 1'b1;
        done_sel = q_head.done;
      end
      default: begin
        byte_sel = '0;
      end
    endcase
  end

  // slot counter walks the bytes of the head point
  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= SLOT_COL_CMD;
    end else if (q_pop) begin
      slot <= SLOT_COL_CMD;
    end else if (load_out && q_valid) begin
      slot <= slot + SLOT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out && q_valid) begin
      if (q_head.clip) begin
        m_tdata                 <= '0;
        m_tuser[USER_CMD_BIT]   <= 1'b0;
        m_tuser[USER_VALID_BIT] <= 1'b0;
        m_tuser[USER_DONE_BIT]  <= q_head.done;
        m_tlast                 <= 1'b1;
      end else begin
        m_tdata                 <= byte_sel;
        m_tuser[USER_CMD_BIT]   <= cmd_sel;
        m_tuser[USER_VALID_BIT] <= 1'b1;
        m_tuser[USER_DONE_BIT]  <= done_sel;
        m_tlast                 <= last_sel;
      end
    end
  end

  `LRD_ASSERT(a_slot_bound, clk, rst, slot <= SLOT_CLR_LO)
  `LRD_ASSERT_NEXT(a_pop_shows_last, clk, rst, q_pop, m_tvalid && m_tlast)
  `LRD_ASSERT_NEXT(a_hold_stalled, clk, rst, m_tvalid && !m_tready, m_tvalid)

endmodule

@@ rtl/core/line_raster_to_display_writes.sv @@
`timescale 1ns / 1ps
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   tdata: x_start y_start x_end y_end pixel_color; tuser: kind
// m_*       out  m_tvalid/m_tready   tdata: out_byte; tuser: is_command byte_valid line_done;
//                                    tlast: last_of_point
// cfg_*     in   cfg_we              cfg_index selects panel_width or panel_height
//
// an input item is taken every cycle while the point queue has room
// a visible point leaves as 13 bytes, a clipped point as one marker
// the output byte rate of the back end (one byte per cycle while m_tready is high) sets the point rate
// first byte passes through the point queue and the output register after the step item is accepted
// rst is synchronous; it empties the queue, drops the active line and
// restores panel width 240 and height 320
// a stall on m_tready fills the queue, then s_tready falls
module line_raster_to_display_writes #(
  parameter int COORD_BITS  = lrd_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = lrd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // x_start, y_start, x_end, y_end, pixel_color
  input  logic [lrd_pkg::IN_DATA_W-1:0]  s_tdata,
  // kind
  input  logic [lrd_pkg::IN_USER_W-1:0]  s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // out_byte
  output logic [lrd_pkg::OUT_DATA_W-1:0] m_tdata,
  // is_command, byte_valid, line_done
  output logic [lrd_pkg::OUT_USER_W-1:0] m_tuser,
  // last_of_point
  output logic                           m_tlast,
  input  logic                           cfg_we,
  input  logic [lrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrd_pkg::FIELD_W-1:0]    cfg_data
);
  import lrd_pkg::*;

  logic [FIELD_W-1:0] panel_width, panel_height;
  logic               q_push, q_full, q_pop, q_valid;
  point_t             q_in, q_head;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      panel_width  <= PANEL_WIDTH_RST;
      panel_height <= PANEL_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PANEL_WIDTH:  panel_width  <= cfg_data;
        CFG_PANEL_HEIGHT: panel_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // stepping and classification
  lrd_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .panel_width (panel_width),
    .panel_height(panel_height),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  // point queue between front and back
  lrd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .head     (q_head)
  );

  // byte serializer
  lrd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
  import lrd_pkg::*;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 345;
  localparam int PHASES        = 6;
  localparam int REPORT_LIMIT  = 100;

  // one byte as seen on the display link
  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_command;
    logic       byte_valid;
    logic       last_of_point;
    logic       line_done;
  } disp_byte_t;

  typedef enum logic [1:0] {READY_ALWAYS, READY_LIGHT, READY_HEAVY} ready_mode_t;

  // line walker and the bytes it still owes the display
  class raster_scoreboard;
    logic [FIELD_W-1:0]        width_reg;
    logic [FIELD_W-1:0]        height_reg;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] end_x;
    logic signed [FIELD_W-1:0] end_y;
    logic [16:0]               span_x_abs;
    logic signed [16:0]        span_y_neg;
    logic                      step_x_down;
    logic                      step_y_down;
    logic signed [17:0]        err_acc;
    logic [FIELD_W-1:0]        line_rgb;
    bit                        drawing;
    disp_byte_t                pending[$];
    int                        fails;

    function new();
      width_reg   = PANEL_WIDTH_RST;
      height_reg  = PANEL_HEIGHT_RST;
      pos_x       = '0;
      pos_y       = '0;
      end_x       = '0;
      end_y       = '0;
      span_x_abs  = '0;
      span_y_neg  = '0;
      step_x_down = 1'b0;
      step_y_down = 1'b0;
      err_acc     = '0;
      line_rgb    = '0;
      drawing     = 1'b0;
      fails       = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [FIELD_W-1:0] value);
      if (idx == CFG_PANEL_WIDTH) begin
        width_reg = value;
      end else if (idx == CFG_PANEL_HEIGHT) begin
        height_reg = value;
      end
    endfunction

    function void push_byte(logic [7:0] b, logic cmd, logic last, logic done);
      disp_byte_t r;
      r.out_byte      = b;
      r.is_command    = cmd;
      r.byte_valid    = 1'b1;
      r.last_of_point = last;
      r.line_done     = done;
      pending.push_back(r);
    endfunction

    // returns 0 only for a step with no line to draw
    function bit note_request(logic kind, logic [IN_DATA_W-1:0] data);
      logic signed [FIELD_W-1:0] x0, y0, x1, y1;
      logic [FIELD_W-1:0] col, row;
      logic at_end;
      int dx, dy, e, e2, sx, sy;
      disp_byte_t marker;
      // load: latch endpoints and set up the error term
      if (kind == KIND_LOAD) begin
        x0 = data[X_START_LSB +: FIELD_W];
        y0 = data[Y_START_LSB +: FIELD_W];
        x1 = data[X_END_LSB +: FIELD_W];
        y1 = data[Y_END_LSB +: FIELD_W];
        dx = int'(x1) - int'(x0);
        dy = int'(y1) - int'(y0);
        sx = (dx < 0) ? -dx : dx;
        sy = (dy < 0) ? dy : -dy;
        pos_x       = x0;
        pos_y       = y0;
        end_x       = x1;
        end_y       = y1;
        span_x_abs  = 17'(sx);
        span_y_neg  = 17'(sy);
        step_x_down = !(x0 < x1);
        step_y_down = !(y0 < y1);
        err_acc     = 18'(sx + sy);
        line_rgb    = data[COLOR_LSB +: FIELD_W];
        drawing     = 1'b1;
        return 1'b1;
      end
      if (!drawing) begin
        return 1'b0;
      end
      // rotate to panel coordinates and clip
      col    = width_reg - pos_y;
      row    = pos_x;
      at_end = (pos_x == end_x) && (pos_y == end_y);
      if (col >= width_reg || row >= height_reg) begin
        marker               = '0;
        marker.last_of_point = 1'b1;
        marker.line_done     = at_end;
        pending.push_back(marker);
      end else begin
        push_byte(CMD_COLUMN, 1'b1, 1'b0, 1'b0);
        push_byte(col[15:8], 1'b0, 1'b0, 1'b0);
        push_byte(col[7:0], 1'b0, 1'b0, 1'b0);
        push_byte(col[15:8], 1'b0, 1'b0, 1'b0);
        push_byte(col[7:0], 1'b0, 1'b0, 1'b0);
        push_byte(CMD_ROW, 1'b1, 1'b0, 1'b0);
        push_byte(row[15:8], 1'b0, 1'b0, 1'b0);
        push_byte(row[7:0], 1'b0, 1'b0, 1'b0);
        push_byte(row[15:8], 1'b0, 1'b0, 1'b0);
        push_byte(row[7:0], 1'b0, 1'b0, 1'b0);
        push_byte(CMD_WRITE, 1'b1, 1'b0, 1'b0);
        push_byte(line_rgb[15:8], 1'b0, 1'b0, 1'b0);
        push_byte(line_rgb[7:0], 1'b0, 1'b1, at_end);
      end
      // advance one point, both axes tested against the old error
      if (at_end) begin
        drawing = 1'b0;
      end else begin
        sx = int'(span_x_abs);
        sy = int'(span_y_neg);
        e  = int'(err_acc);
        e2 = 2 * e;
        if (e2 >= sy) begin
          e += sy;
          pos_x = 16'(pos_x + (step_x_down ? -1 : 1));
        end
        if (e2 <= sx) begin
          e += sx;
          pos_y = 16'(pos_y + (step_y_down ? -1 : 1));
        end
        err_acc = 18'(e);
      end
      return 1'b1;
    endfunction

    function void report(string field, logic [7:0] want, logic [7:0] got);
      fails++;
      if (fails <= REPORT_LIMIT) begin
        $error("%s: expected %0h, got %0h", field, want, got);
      end
    endfunction

    function void check_byte(disp_byte_t got);
      disp_byte_t want;
      if (pending.size() == 0) begin
        fails++;
        if (fails <= REPORT_LIMIT) begin
          $error("byte %0h arrived with no point pending", got.out_byte);
        end
        return;
      end
      want = pending.pop_front();
      if (got.out_byte !== want.out_byte)
        report("out_byte", want.out_byte, got.out_byte);
      if (got.is_command !== want.is_command)
        report("is_command", 8'(want.is_command), 8'(got.is_command));
      if (got.byte_valid !== want.byte_valid)
        report("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
      if (got.last_of_point !== want.last_of_point)
        report("last_of_point", 8'(want.last_of_point), 8'(got.last_of_point));
      if (got.line_done !== want.line_done)
        report("line_done", 8'(want.line_done), 8'(got.line_done));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  m_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [FIELD_W-1:0]    cfg_data = '0;

  raster_scoreboard sb;
  int               burst_left = 0;
  int               items_taken = 0;
  int               quiet_cycles = 0;
  ready_mode_t      ready_mode = READY_ALWAYS;
  int               mode_left = 0;

  line_raster_to_display_writes uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // receiver stall pattern, switching mode every so often
  always @(posedge clk) begin
    if (mode_left == 0) begin
      ready_mode <= ready_mode_t'($urandom_range(0, 2));
      mode_left  <= $urandom_range(40, 300);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (ready_mode)
      READY_ALWAYS: m_tready <= 1'b1;
      READY_LIGHT:  m_tready <= ($urandom_range(0, 3) != 0);
      default:      m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // output check and watchdog, sampled mid-cycle
  always @(negedge clk) begin
    disp_byte_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.out_byte      = m_tdata;
        got.is_command    = m_tuser[USER_CMD_BIT];
        got.byte_valid    = m_tuser[USER_VALID_BIT];
        got.last_of_point = m_tlast;
        got.line_done     = m_tuser[USER_DONE_BIT];
        sb.check_byte(got);
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // one request, with bursty gaps on the sender side
  task automatic send_item(input logic kind, input logic [IN_DATA_W-1:0] data);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= data;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    if (sb.note_request(kind, data))
      items_taken++;
    @(posedge clk);
    burst_left--;
  endtask

  // load a line, then step it a number of times
  task automatic send_line(input logic [15:0] x0, input logic [15:0] y0,
                           input logic [15:0] x1, input logic [15:0] y1,
                           input logic [15:0] rgb, input int steps);
    send_item(KIND_LOAD, {rgb, y1, x1, y0, x0});
    repeat (steps) send_item(KIND_STEP, IN_DATA_W'({$urandom, $urandom, $urandom}));
  endtask

  // wait until every byte is out, then let the pipeline empty
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_panel(input logic [15:0] w, input logic [15:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PANEL_WIDTH;
    cfg_data  <= w;
    sb.set_register(CFG_PANEL_WIDTH, w);
    @(posedge clk);
    cfg_index <= CFG_PANEL_HEIGHT;
    cfg_data  <= h;
    sb.set_register(CFG_PANEL_HEIGHT, h);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly near the visible range, sometimes anywhere
  function automatic logic [15:0] pick_coord(logic [15:0] dim);
    int lim;
    lim = (dim > 400) ? 400 : int'(dim);
    if ($urandom_range(0, 4) == 0)
      return 16'($urandom);
    return 16'(int'($urandom_range(0, lim + 6)) - 3);
  endfunction

  // short lines walked to the end, some cut short or stepped past the end
  task automatic random_line();
    logic [15:0] x0, y0, x1, y1;
    int adx, ady, n, steps;
    x0 = pick_coord(sb.height_reg);
    y0 = pick_coord(sb.width_reg);
    if ($urandom_range(0, 7) == 0) begin
      x1 = 16'($urandom);
      y1 = 16'($urandom);
    end else begin
      x1 = x0 + 16'($urandom_range(0, 24)) - 16'd12;
      y1 = y0 + 16'($urandom_range(0, 24)) - 16'd12;
    end
    adx = int'($signed(x1)) - int'($signed(x0));
    ady = int'($signed(y1)) - int'($signed(y0));
    if (adx < 0) adx = -adx;
    if (ady < 0) ady = -ady;
    n = ((adx > ady) ? adx : ady) + 1;
    if (n > 40)
      steps = $urandom_range(1, 6);
    else if ($urandom_range(0, 9) < 7)
      steps = n + $urandom_range(0, 2);
    else
      steps = $urandom_range(1, n);
    send_line(x0, y0, x1, y1, 16'($urandom), steps);
  endtask

  initial begin
    logic [15:0] widths[PHASES];
    logic [15:0] heights[PHASES];
    int target;
    sb = new();
    widths[0] = 16'hFFFF;  heights[0] = 16'hFFFF;
    widths[1] = 16'h0000;  heights[1] = PANEL_HEIGHT_RST;
    widths[2] = 16'h0001;  heights[2] = 16'h0001;
    widths[3] = PANEL_WIDTH_RST; heights[3] = 16'h0000;
    widths[4] = 16'($urandom_range(1, 400)); heights[4] = 16'($urandom_range(1, 400));
    widths[5] = 16'd320;   heights[5] = 16'd240;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: idle step, single point, panel corners, vertical, extremes, steep
    send_item(KIND_STEP, '1);
    send_line(16'd10, 16'd20, 16'd10, 16'd20, 16'hFFFF, 2);
    send_line(16'd0, 16'd240, 16'd3, 16'd237, 16'h0000, 4);
    send_line(16'd319, 16'd1, 16'd320, 16'd0, 16'h1234, 2);
    send_line(16'd5, 16'd5, 16'd5, 16'd1, 16'h5A5A, 2);
    send_line(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'hA5A5, 2);
    send_line(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'hC3C3, 2);
    send_line(16'd100, 16'd100, 16'd102, 16'd110, 16'h0F0F, 3);

    // random lines under several panel sizes
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_panel(widths[p], heights[p]);
      target = items_taken + RANDOM_ITEMS / PHASES;
      while (items_taken < target) random_line();
    end
    settle();

    if (sb.fails == 0 && sb.pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
